/* hdl/sntp_client_exchange_controller_core_assert.svh */
// ----------------------------------------------------------------------------
// SNTP client exchange controller assertion macros
// Concurrent assertion shorthands clocked on clk_i, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef SNTP_CLIENT_EXCHANGE_CONTROLLER_CORE_ASSERT_SVH
`define SNTP_CLIENT_EXCHANGE_CONTROLLER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SNTPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sntpc: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SNTPC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sntpc: next-cycle check failed");

`endif

/* hdl/sntpc_pkg.sv */
// ----------------------------------------------------------------------------
// SNTP client exchange controller package
// Codes, payload structs and state types shared by the controller modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sntpc_pkg;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 31;
  localparam logic [15:0] NtpHdrBytes = 16'd48;

  typedef enum logic [1:0] {
    ACT_START    = 2'd0,
    ACT_TICK     = 2'd1,
    ACT_RESPONSE = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_WAITING = 3'd0,
    ST_SEND    = 3'd1,
    ST_TIME    = 3'd2,
    ST_KISS    = 3'd3,
    ST_TIMEOUT = 3'd4,
    ST_IDLE    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_DONE = 2'd2
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_REQUEST_VERSION = 2'd0,
    REG_OVERALL_TIMEOUT = 2'd1,
    REG_INIT_RTX        = 2'd2,
    REG_MAX_RTX         = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] now;
    logic [15:0] rx_length;
    logic [2:0]  rx_version;
    logic [2:0]  rx_mode;
    logic [7:0]  rx_stratum;
    logic [31:0] rx_reference_id;
    logic [31:0] rx_transmit_seconds;
    logic [31:0] rx_transmit_fraction;
    logic [31:0] rx_originate_seconds;
    logic [31:0] rx_originate_fraction;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  request_version_res;
    logic [31:0] request_stamp;
    logic [31:0] server_seconds;
    logic [31:0] server_fraction;
    logic [31:0] kiss_code;
  } out_t;

  typedef struct packed {
    logic [2:0]  request_version;
    logic [30:0] overall_timeout;
    logic [30:0] init_rtx;
    logic [30:0] max_rtx;
  } cfg_t;

  typedef struct packed {
    phase_e      phase;
    logic [31:0] start_time;
    logic [31:0] send_time;
    logic [30:0] rtx_wait;
  } state_t;

endpackage

/* hdl/sntp_client_exchange_controller_core.sv */
// ----------------------------------------------------------------------------
// sntp_client_exchange_controller_core: SNTP client request/response control.
// An accepted beat is held in the input register, then evaluated and registered as the result beat.
// Throughput: one beat per cycle while out_ready_i takes each result, set by the single evaluation stage.
// Reset (rst_ni low, async): idle phase, empty stages, default config values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sntp_client_exchange_controller_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sntpc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sntpc_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  sntpc_pkg::in_t                  in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output sntpc_pkg::out_t                 out_data_o
);
  import sntpc_pkg::*;

  cfg_t   cfg;
  state_t state_q, state_d;
  in_t    in_q;
  out_t   out_q, res;
  logic   in_vld_q, out_vld_q, adv;

  sntpc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  sntpc_eval u_eval (
    .item_i  (in_q),
    .state_i (state_q),
    .cfg_i   (cfg),
    .state_o (state_d),
    .res_o   (res)
  );

  // The held beat moves into the result register when that register frees up.
  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q           <= 1'b0;
      out_vld_q          <= 1'b0;
      state_q.phase      <= PH_IDLE;
      state_q.start_time <= '0;
      state_q.send_time  <= '0;
      state_q.rtx_wait   <= '0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

/* hdl/sntpc_cfg.sv */
// ----------------------------------------------------------------------------
// SNTP client configuration registers
// Write-only register file holding the version and the three timeouts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sntpc_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sntpc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sntpc_pkg::CfgDataW-1:0]  cfg_data_i,
  output sntpc_pkg::cfg_t                 cfg_o
);
  import sntpc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_REQUEST_VERSION: cfg_d.request_version = cfg_data_i[2:0];
        REG_OVERALL_TIMEOUT: cfg_d.overall_timeout = cfg_data_i;
        REG_INIT_RTX:        cfg_d.init_rtx        = cfg_data_i;
        REG_MAX_RTX:         cfg_d.max_rtx         = cfg_data_i;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.request_version <= 3'd4;
      cfg_q.overall_timeout <= 31'd30000;
      cfg_q.init_rtx        <= 31'd2000;
      cfg_q.max_rtx         <= 31'd15000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/sntpc_eval.sv */
// ----------------------------------------------------------------------------
// SNTP client exchange evaluation
// Decides the result of one beat and the next exchange state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sntpc_eval (
  input  sntpc_pkg::in_t    item_i,
  input  sntpc_pkg::state_t state_i,
  input  sntpc_pkg::cfg_t   cfg_i,
  output sntpc_pkg::state_t state_o,
  output sntpc_pkg::out_t   res_o
);
  import sntpc_pkg::*;

  logic [31:0] ovr_dl, rtx_dl, ovr_diff, rtx_diff, dbl_wait, max_wait;
  logic        ovr_hit, rtx_hit, rsp_ok;

  // Deadlines wrap modulo 2^32; a non-negative signed difference means reached.
  assign ovr_dl   = state_i.start_time + {1'b0, cfg_i.overall_timeout};
  assign rtx_dl   = state_i.send_time + {1'b0, state_i.rtx_wait};
  assign ovr_diff = item_i.now - ovr_dl;
  assign rtx_diff = item_i.now - rtx_dl;
  assign ovr_hit  = ~ovr_diff[31];
  assign rtx_hit  = ~rtx_diff[31];
  assign dbl_wait = {state_i.rtx_wait, 1'b0};
  assign max_wait = {1'b0, cfg_i.max_rtx};

  assign rsp_ok = (item_i.rx_length >= NtpHdrBytes) && (item_i.rx_version != 3'd0) &&
                  ((item_i.rx_transmit_seconds != 32'd0) ||
                   (item_i.rx_transmit_fraction != 32'd0)) &&
                  ((item_i.rx_mode == 3'd4) || (item_i.rx_mode == 3'd5)) &&
                  (item_i.rx_originate_seconds == 32'd0) &&
                  (item_i.rx_originate_fraction == state_i.send_time);

  always_comb begin
    state_o = state_i;
    res_o   = '0;
    if (item_i.action == ACT_START) begin
      state_o.phase      = PH_WAIT;
      state_o.start_time = item_i.now;
      state_o.send_time  = item_i.now;
      state_o.rtx_wait   = cfg_i.init_rtx;
      res_o.status              = ST_SEND;
      res_o.request_version_res = cfg_i.request_version;
      res_o.request_stamp       = item_i.now;
    end else if (state_i.phase != PH_WAIT) begin
      res_o.status = ST_IDLE;
    end else if ((item_i.action == ACT_RESPONSE) && rsp_ok) begin
      state_o.phase = PH_DONE;
      if (item_i.rx_stratum == 8'd0) begin
        res_o.status    = ST_KISS;
        res_o.kiss_code = item_i.rx_reference_id;
      end else begin
        res_o.status          = ST_TIME;
        res_o.server_seconds  = item_i.rx_transmit_seconds;
        res_o.server_fraction = item_i.rx_transmit_fraction;
      end
    end else if (ovr_hit) begin
      // An invalid response falls through here and is treated as a tick.
      state_o.phase = PH_DONE;
      res_o.status  = ST_TIMEOUT;
    end else if (rtx_hit) begin
      state_o.send_time = item_i.now;
      state_o.rtx_wait  = (dbl_wait < max_wait) ? dbl_wait[30:0] : cfg_i.max_rtx;
      res_o.status              = ST_SEND;
      res_o.request_version_res = cfg_i.request_version;
      res_o.request_stamp       = item_i.now;
    end else begin
      res_o.status = ST_WAITING;
    end
  end

endmodule

/* hdl/sntpc_checker.sv */
// ----------------------------------------------------------------------------
// SNTP client exchange port checker
// Watches the result-side ports of the core and checks result beats for consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sntp_client_exchange_controller_core_assert.svh"

module sntpc_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input sntpc_pkg::out_t out_data_i
);
  import sntpc_pkg::*;

  logic is_send, is_time, is_kiss;
  logic out_stall, req_clear, srv_clear, kiss_clear;

  assign is_send = out_data_i.status == ST_SEND;
  assign is_time = out_data_i.status == ST_TIME;
  assign is_kiss = out_data_i.status == ST_KISS;

  assign out_stall  = out_valid_i && !out_ready_i;
  assign req_clear  = (out_data_i.request_stamp == 32'd0) &&
                      (out_data_i.request_version_res == 3'd0);
  assign srv_clear  = (out_data_i.server_seconds == 32'd0) &&
                      (out_data_i.server_fraction == 32'd0);
  assign kiss_clear = out_data_i.kiss_code == 32'd0;

  // A stalled result beat must hold.
  `SNTPC_ASSERT_NXT(a_out_hold, out_stall, out_valid_i && $stable(out_data_i))
  // Request fields are only filled for a send request.
  `SNTPC_ASSERT_NOW(a_req_zero, out_valid_i && !is_send, req_clear)
  // Server time is only reported with a time result.
  `SNTPC_ASSERT_NOW(a_srv_zero, out_valid_i && !is_time, srv_clear)
  // The kiss code is only reported with a kiss result.
  `SNTPC_ASSERT_NOW(a_kiss_zero, out_valid_i && !is_kiss, kiss_clear)

endmodule

bind sntp_client_exchange_controller_core sntpc_checker u_sntpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);
